@@ sv/assert_macros.svh @@
// assertion helpers shared by bnsh_queue and the top rtl file
// both expect signals named clk and rst in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BNSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true at a clock edge outside reset
`define BNSH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ sv/bnsh_pkg.sv @@
`default_nettype none

package bnsh_pkg;

  // field widths
  localparam int unsigned IDX_W = 10;
  localparam int unsigned LEN_W = 31;

  // arithmetic widths in the front pipeline
  localparam int unsigned DIFF_W = 33;
  localparam int unsigned PROD_W = 49;
  localparam int unsigned DOT_W  = 51;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned SUM_W  = 66;
  localparam int unsigned AA_W   = 62;

  // front pipeline depth and the width of its occupancy count
  localparam int unsigned FRONT_STAGES = 6;
  localparam int unsigned INFL_W       = 3;

  // register file
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned REG_IDX_BIT = 2;
  localparam logic REG_MAX_LENGTH  = 1'b0;
  localparam logic REG_BEAM_MARGIN = 1'b1;

  localparam logic [LEN_W-1:0] LEN_MAX      = 31'h7FFF_FFFF;
  localparam logic [LEN_W-1:0] MARGIN_RESET = 31'd65536;

  // item kinds
  localparam logic OP_SHOT = 1'b0;
  localparam logic OP_BODY = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    logic             op;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] val;   // range on a shot, along distance on a body
    logic             ok;    // body in front, alive, not shooter, along distance within 31 bits, inside the beam
  } mid_entry_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_index;
    logic [LEN_W-1:0] beam_length;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

@@ sv/bnsh_queue.sv @@
`default_nettype none

`include "assert_macros.svh"

module bnsh_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         rd,
  output logic [WIDTH-1:0]             rdata,
  output bnsh_pkg::q_status_t          status,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rdata        = slots[rptr];
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

  `BNSH_NEVER(a_no_overflow, wr && status.full, "queue written while full")
  `BNSH_NEVER(a_no_underflow, rd && status.empty, "queue read while empty")
  `BNSH_ASSERT(a_count_up, !$past(rst) && $past(wr) && !$past(rd) |-> count == $past(count) + 1'b1, "queue count did not follow a write")

endmodule

`default_nettype wire

@@ sv/bnsh_front.sv @@
`default_nettype none

module bnsh_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                op,
  input  logic [bnsh_pkg::IDX_W-1:0]          body_index,
  input  logic signed [31:0]                  pos_x,
  input  logic signed [31:0]                  pos_y,
  input  logic signed [31:0]                  pos_z,
  input  logic signed [15:0]                  dir_x,
  input  logic signed [15:0]                  dir_y,
  input  logic signed [15:0]                  dir_z,
  input  logic [bnsh_pkg::LEN_W-1:0]          radius,
  input  logic                                alive,
  input  logic [bnsh_pkg::LEN_W-1:0]          beam_range,
  input  logic                                last,
  input  logic [bnsh_pkg::LEN_W-1:0]          beam_margin,
  output logic                                out_valid,
  output bnsh_pkg::mid_entry_t                out_entry,
  output logic [bnsh_pkg::INFL_W-1:0]         inflight
);

  // shooter held from the latest shot
  logic [bnsh_pkg::IDX_W-1:0] shooter_id;
  logic signed [31:0]         shooter_pos [3];
  logic signed [15:0]         forward_dir [3];

  logic signed [31:0]         pos_in [3];
  logic signed [15:0]         dir_in [3];

  // stage 1: offsets and their magnitudes
  logic                        v1, op1, last1, skip1;
  logic [bnsh_pkg::IDX_W-1:0]  idx1;
  logic [bnsh_pkg::LEN_W-1:0]  val1;
  logic signed [bnsh_pkg::DIFF_W-1:0] d1 [3];
  logic [31:0]                 m1 [3];
  logic signed [15:0]          dir1 [3];
  logic [31:0]                 rw1;

  logic signed [bnsh_pkg::DIFF_W-1:0] d_c [3];
  logic [bnsh_pkg::DIFF_W-1:0]        neg_c [3];

  // stage 2: products
  logic                        v2, op2, last2, skip2;
  logic [bnsh_pkg::IDX_W-1:0]  idx2;
  logic [bnsh_pkg::LEN_W-1:0]  val2;
  logic signed [bnsh_pkg::PROD_W-1:0] pr2 [3];
  logic [bnsh_pkg::SQ_W-1:0]   sq2 [3];
  logic [bnsh_pkg::SQ_W-1:0]   rwsq2;

  // stage 3: sums
  logic                        v3, op3, last3, skip3;
  logic [bnsh_pkg::IDX_W-1:0]  idx3;
  logic [bnsh_pkg::LEN_W-1:0]  val3;
  logic [bnsh_pkg::DOT_W-1:0]  dot3;
  logic [bnsh_pkg::SUM_W-1:0]  ssum3;
  logic [bnsh_pkg::SQ_W-1:0]   rwsq3;

  // stage 4: along distance and its square
  logic                        v4, op4, last4, ok4;
  logic [bnsh_pkg::IDX_W-1:0]  idx4;
  logic [bnsh_pkg::LEN_W-1:0]  val4;
  logic [bnsh_pkg::AA_W-1:0]   aa4;
  logic [bnsh_pkg::SUM_W-1:0]  ssum4;
  logic [bnsh_pkg::SQ_W-1:0]   rwsq4;

  logic                        in_front3, fits3;
  logic [bnsh_pkg::LEN_W-1:0]  along3;

  // stage 5: perpendicular distance squared
  logic                        v5, op5, last5, ok5;
  logic [bnsh_pkg::IDX_W-1:0]  idx5;
  logic [bnsh_pkg::LEN_W-1:0]  val5;
  logic [bnsh_pkg::SUM_W-1:0]  perp5;
  logic [bnsh_pkg::SQ_W-1:0]   rwsq5;

  logic [bnsh_pkg::SUM_W-1:0]  aa_ext4;

  // stage 6: beam test, handed to the queue
  logic                        v6;
  bnsh_pkg::mid_entry_t        entry6;

  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;
  assign dir_in[0] = dir_x;
  assign dir_in[1] = dir_y;
  assign dir_in[2] = dir_z;

  // shooter latch on a shot beat
  always_ff @(posedge clk) begin
    if (rst) begin
      shooter_id <= '0;
      for (int i = 0; i < 3; i++) begin
        shooter_pos[i] <= '0;
        forward_dir[i] <= '0;
      end
    end else if (accept && op == bnsh_pkg::OP_SHOT) begin
      shooter_id <= body_index;
      for (int i = 0; i < 3; i++) begin
        shooter_pos[i] <= pos_in[i];
        forward_dir[i] <= dir_in[i];
      end
    end
  end

  // offset from the shooter, sign extended, and its magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i]   = {pos_in[i][31], pos_in[i]} - {shooter_pos[i][31], shooter_pos[i]};
      neg_c[i] = -d_c[i];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    op1   <= op;
    last1 <= last;
    idx1  <= body_index;
    skip1 <= (body_index == shooter_id) || !alive;
    val1  <= beam_range;
    rw1   <= {1'b0, radius} + {1'b0, beam_margin};
    for (int i = 0; i < 3; i++) begin
      d1[i]   <= d_c[i];
      m1[i]   <= d_c[i][bnsh_pkg::DIFF_W-1] ? neg_c[i][31:0] : d_c[i][31:0];
      dir1[i] <= forward_dir[i];
    end
  end

  // stage 2 payload: one multiplier per term
  always_ff @(posedge clk) begin
    op2   <= op1;
    last2 <= last1;
    idx2  <= idx1;
    skip2 <= skip1;
    val2  <= val1;
    rwsq2 <= rw1 * rw1;
    for (int i = 0; i < 3; i++) begin
      pr2[i] <= d1[i] * dir1[i];
      sq2[i] <= m1[i] * m1[i];
    end
  end

  // stage 3 payload: dot product and squared length
  always_ff @(posedge clk) begin
    op3   <= op2;
    last3 <= last2;
    idx3  <= idx2;
    skip3 <= skip2;
    val3  <= val2;
    rwsq3 <= rwsq2;
    dot3  <= {{2{pr2[0][bnsh_pkg::PROD_W-1]}}, pr2[0]}
           + {{2{pr2[1][bnsh_pkg::PROD_W-1]}}, pr2[1]}
           + {{2{pr2[2][bnsh_pkg::PROD_W-1]}}, pr2[2]};
    ssum3 <= {2'b00, sq2[0]} + {2'b00, sq2[1]} + {2'b00, sq2[2]};
  end

  // in front, and along distance within 31 bits
  assign in_front3 = !dot3[bnsh_pkg::DOT_W-1] && (dot3 != '0);
  assign fits3     = (dot3[bnsh_pkg::DOT_W-1:45] == '0);
  assign along3    = dot3[44:14];

  // stage 4 payload
  always_ff @(posedge clk) begin
    op4   <= op3;
    last4 <= last3;
    idx4  <= idx3;
    ok4   <= !skip3 && in_front3 && fits3;
    val4  <= (op3 == bnsh_pkg::OP_SHOT) ? val3 : along3;
    aa4   <= along3 * along3;
    ssum4 <= ssum3;
    rwsq4 <= rwsq3;
  end

  assign aa_ext4 = {4'b0000, aa4};

  // stage 5 payload: clamp at zero
  always_ff @(posedge clk) begin
    op5   <= op4;
    last5 <= last4;
    idx5  <= idx4;
    ok5   <= ok4;
    val5  <= val4;
    rwsq5 <= rwsq4;
    perp5 <= (ssum4 >= aa_ext4) ? ssum4 - aa_ext4 : '0;
  end

  // stage 6 payload: beam radius test
  always_ff @(posedge clk) begin
    entry6.op   <= op5;
    entry6.last <= last5;
    entry6.idx  <= idx5;
    entry6.val  <= val5;
    entry6.ok   <= (op5 == bnsh_pkg::OP_BODY) && ok5 && (perp5 < {2'b00, rwsq5});
  end

  assign out_valid = v6;
  assign out_entry = entry6;
  assign inflight  = bnsh_pkg::INFL_W'(v1) + bnsh_pkg::INFL_W'(v2) + bnsh_pkg::INFL_W'(v3)
                   + bnsh_pkg::INFL_W'(v4) + bnsh_pkg::INFL_W'(v5) + bnsh_pkg::INFL_W'(v6);

endmodule

`default_nettype wire

@@ sv/bnsh_back.sv @@
`default_nettype none

module bnsh_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bnsh_pkg::LEN_W-1:0]    max_length,
  input  logic                          in_valid,
  input  bnsh_pkg::mid_entry_t          in_entry,
  output logic                          in_take,
  input  logic                          res_full,
  output logic                          res_wr,
  output bnsh_pkg::result_t             res
);

  logic [bnsh_pkg::LEN_W-1:0] best_along, best_along_next;
  logic [bnsh_pkg::IDX_W-1:0] best_id, best_id_next;
  logic                       found_any, found_any_next;
  logic [bnsh_pkg::LEN_W-1:0] range_held, range_held_next;

  // a closing beat needs room for its result
  assign in_take = in_valid && (!in_entry.last || !res_full);
  assign res_wr  = in_take && in_entry.last;

  // restart on a shot, keep the nearest passing body
  always_comb begin
    best_along_next = best_along;
    best_id_next    = best_id;
    found_any_next  = found_any;
    range_held_next = range_held;
    if (in_take) begin
      if (in_entry.op == bnsh_pkg::OP_SHOT) begin
        best_along_next = max_length;
        best_id_next    = '0;
        found_any_next  = 1'b0;
        range_held_next = in_entry.val;
      end else if (in_entry.ok && (in_entry.val < best_along)) begin
        best_along_next = in_entry.val;
        best_id_next    = in_entry.idx;
        found_any_next  = 1'b1;
      end
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      best_along <= bnsh_pkg::LEN_MAX;
      best_id    <= '0;
      found_any  <= 1'b0;
      range_held <= '0;
    end else begin
      best_along <= best_along_next;
      best_id    <= best_id_next;
      found_any  <= found_any_next;
      range_held <= range_held_next;
    end
  end

  // result from the state after this beat
  assign res.hit         = found_any_next;
  assign res.hit_index   = found_any_next ? best_id_next : '0;
  assign res.beam_length = found_any_next ? best_along_next : range_held_next;

endmodule

`default_nettype wire

@@ sv/beam_nearest_sphere_hit.sv @@
// channel   dir  handshake                      payload
// input     in   push / full                    op body_index pos_* dir_* radius alive
//                                               beam_range last
// result    out  empty / pop                    hit hit_index beam_length
// config    in   psel penable pwrite pready     paddr pwdata, read back on prdata
//
// one item is taken per cycle while full is low; a six stage arithmetic pipeline
// classifies it and the keep compare in the back part retires one queued item per
// cycle unless a closing item finds the result queue full
// full rises when the front pipeline plus the middle queue hold MID_DEPTH items
// a stalled result side holds two results, then the back part waits, then full rises
// synchronous reset clears control state and sets the registers to their defaults
`default_nettype none

`include "assert_macros.svh"

module beam_nearest_sphere_hit #(
  parameter int MID_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // input queue side
  input  logic                              push,
  output logic                              full,
  input  logic                              op,
  input  logic [bnsh_pkg::IDX_W-1:0]        body_index,
  input  logic signed [31:0]                pos_x,
  input  logic signed [31:0]                pos_y,
  input  logic signed [31:0]                pos_z,
  input  logic signed [15:0]                dir_x,
  input  logic signed [15:0]                dir_y,
  input  logic signed [15:0]                dir_z,
  input  logic [bnsh_pkg::LEN_W-1:0]        radius,
  input  logic                              alive,
  input  logic [bnsh_pkg::LEN_W-1:0]        beam_range,
  input  logic                              last,
  // result queue side
  output logic                              empty,
  input  logic                              pop,
  output logic                              hit,
  output logic [bnsh_pkg::IDX_W-1:0]        hit_index,
  output logic [bnsh_pkg::LEN_W-1:0]        beam_length,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bnsh_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int MCW  = $clog2(MID_DEPTH+1);
  localparam int SUMW = MCW + bnsh_pkg::INFL_W;
  localparam int MEW  = $bits(bnsh_pkg::mid_entry_t);
  localparam int RSW  = $bits(bnsh_pkg::result_t);
  localparam int RES_DEPTH = 2;

  logic [bnsh_pkg::LEN_W-1:0] max_length;
  logic [bnsh_pkg::LEN_W-1:0] beam_margin;
  logic                       cfg_wr;

  logic                       accept;
  logic                       front_valid;
  bnsh_pkg::mid_entry_t       front_entry;
  logic [bnsh_pkg::INFL_W-1:0] inflight;

  logic [MEW-1:0]             mid_rdata;
  bnsh_pkg::mid_entry_t       mid_entry;
  bnsh_pkg::q_status_t        mid_status;
  logic [MCW-1:0]             mid_count;
  logic                       mid_take;

  logic                       res_wr;
  bnsh_pkg::result_t          res_in;
  logic [RSW-1:0]             res_rdata;
  bnsh_pkg::result_t          res_out;
  bnsh_pkg::q_status_t        res_status;
  logic [$clog2(RES_DEPTH+1)-1:0] res_count;

  logic [SUMW-1:0]            committed;

  // register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length  <= bnsh_pkg::LEN_MAX;
      beam_margin <= bnsh_pkg::MARGIN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[bnsh_pkg::REG_IDX_BIT])
        bnsh_pkg::REG_MAX_LENGTH:  max_length  <= pwdata[bnsh_pkg::LEN_W-1:0];
        bnsh_pkg::REG_BEAM_MARGIN: beam_margin <= pwdata[bnsh_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[bnsh_pkg::REG_IDX_BIT])
      bnsh_pkg::REG_MAX_LENGTH:  prdata = {1'b0, max_length};
      bnsh_pkg::REG_BEAM_MARGIN: prdata = {1'b0, beam_margin};
      default:                   prdata = '0;
    endcase
  end

  // credit check: every beat in flight has a queue slot waiting
  assign committed = SUMW'(mid_count) + SUMW'(inflight);
  assign full      = (committed >= SUMW'(MID_DEPTH));
  assign accept    = push && !full;

  bnsh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .op          (op),
    .body_index  (body_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .dir_z       (dir_z),
    .radius      (radius),
    .alive       (alive),
    .beam_range  (beam_range),
    .last        (last),
    .beam_margin (beam_margin),
    .out_valid   (front_valid),
    .out_entry   (front_entry),
    .inflight    (inflight)
  );

  bnsh_queue #(
    .WIDTH (MEW),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (front_valid),
    .wdata  (front_entry),
    .rd     (mid_take),
    .rdata  (mid_rdata),
    .status (mid_status),
    .count  (mid_count)
  );

  assign mid_entry = mid_rdata;

  bnsh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .max_length (max_length),
    .in_valid   (!mid_status.empty),
    .in_entry   (mid_entry),
    .in_take    (mid_take),
    .res_full   (res_status.full),
    .res_wr     (res_wr),
    .res        (res_in)
  );

  bnsh_queue #(
    .WIDTH (RSW),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (res_wr),
    .wdata  (res_in),
    .rd     (pop && !res_status.empty),
    .rdata  (res_rdata),
    .status (res_status),
    .count  (res_count)
  );

  // result ports
  assign res_out     = res_rdata;
  assign empty       = res_status.empty;
  assign hit         = res_out.hit;
  assign hit_index   = res_out.hit_index;
  assign beam_length = res_out.beam_length;

  `BNSH_ASSERT(a_credit_bound, committed <= SUMW'(MID_DEPTH), "credit above queue room")
  `BNSH_ASSERT(a_result_count, res_count <= RES_DEPTH, "result queue count out of range")

endmodule

`default_nettype wire

@@ tb/sv/beam_hit_checker.sv @@
`timescale 1ns / 1ps

module beam_hit_checker (
  input  logic                        clk,
  input  logic                        rst,
  // input queue side
  input  logic                        push,
  input  logic                        full,
  input  logic                        op,
  input  logic [bnsh_pkg::IDX_W-1:0]  body_index,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          pos_z,
  input  logic signed [15:0]          dir_x,
  input  logic signed [15:0]          dir_y,
  input  logic signed [15:0]          dir_z,
  input  logic [bnsh_pkg::LEN_W-1:0]  radius,
  input  logic                        alive,
  input  logic [bnsh_pkg::LEN_W-1:0]  beam_range,
  input  logic                        last,
  // result queue side
  input  logic                        empty,
  input  logic                        pop,
  input  logic                        hit,
  input  logic [bnsh_pkg::IDX_W-1:0]  hit_index,
  input  logic [bnsh_pkg::LEN_W-1:0]  beam_length,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [bnsh_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  // to the test top
  output int                          mismatches,
  output int                          outstanding
);

  // register copies
  logic [bnsh_pkg::LEN_W-1:0] max_len_reg;
  logic [bnsh_pkg::LEN_W-1:0] margin_reg;

  // current shot and best body so far
  logic [bnsh_pkg::IDX_W-1:0] shooter;
  longint                     shooter_at [3];
  longint                     aim [3];
  logic [bnsh_pkg::LEN_W-1:0] range_kept;
  logic [bnsh_pkg::LEN_W-1:0] nearest_along;
  logic [bnsh_pkg::IDX_W-1:0] nearest_id;
  logic                       struck;

  bnsh_pkg::result_t due_results[$];
  int      fails = 0;
  int      due_count = 0;

  assign mismatches  = fails;
  assign outstanding = due_count;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fails++;
  endtask

  // test one body against the beam and keep it when it is nearer
  function automatic void weigh_body(input logic [bnsh_pkg::IDX_W-1:0] idx,
                                     input logic signed [31:0] px,
                                     input logic signed [31:0] py,
                                     input logic signed [31:0] pz,
                                     input logic [bnsh_pkg::LEN_W-1:0] rad,
                                     input logic live);
    longint       v [3];
    longint       dot;
    logic [63:0]  mag;
    logic [63:0]  along;
    logic [63:0]  reach;
    logic [127:0] span_sq;
    logic [127:0] along_sq;
    logic [127:0] perp_sq;
    logic [127:0] reach_sq;
    v[0] = longint'(px) - shooter_at[0];
    v[1] = longint'(py) - shooter_at[1];
    v[2] = longint'(pz) - shooter_at[2];
    if (idx == shooter || !live)
      return;
    dot = 0;
    span_sq = '0;
    for (int k = 0; k < 3; k++) begin
      dot += v[k] * aim[k];
      mag = (v[k] < 0) ? 64'(-v[k]) : 64'(v[k]);
      span_sq += 128'(mag) * 128'(mag);
    end
    if (dot <= 0)
      return;
    along = 64'(dot) >> 14;
    if (along > 64'(bnsh_pkg::LEN_MAX) || along >= 64'(nearest_along))
      return;
    along_sq = 128'(along) * 128'(along);
    perp_sq  = (span_sq < along_sq) ? '0 : span_sq - along_sq;
    reach    = 64'(rad) + 64'(margin_reg);
    reach_sq = 128'(reach) * 128'(reach);
    if (perp_sq < reach_sq) begin
      nearest_along = along[bnsh_pkg::LEN_W-1:0];
      nearest_id    = idx;
      struck        = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    bnsh_pkg::result_t due;
    bnsh_pkg::result_t seen;
    if (rst) begin
      max_len_reg   = bnsh_pkg::LEN_MAX;
      margin_reg    = bnsh_pkg::MARGIN_RESET;
      shooter       = '0;
      for (int k = 0; k < 3; k++) begin
        shooter_at[k] = 0;
        aim[k]        = 0;
      end
      range_kept    = '0;
      nearest_along = bnsh_pkg::LEN_MAX;
      nearest_id    = '0;
      struck        = 1'b0;
      due_results.delete();
    end else begin
      // result beat against the oldest expectation
      if (pop && !empty) begin
        seen.hit         = hit;
        seen.hit_index   = hit_index;
        seen.beam_length = beam_length;
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("result %0b/%0d/%0d with nothing expected",
                                  hit, hit_index, beam_length));
        end else begin
          due = due_results.pop_front();
          if (seen.hit !== due.hit)
            flag_mismatch($sformatf("hit got %0b want %0b", seen.hit, due.hit));
          if (seen.hit_index !== due.hit_index)
            flag_mismatch($sformatf("hit_index got %0d want %0d",
                                    seen.hit_index, due.hit_index));
          if (seen.beam_length !== due.beam_length)
            flag_mismatch($sformatf("beam_length got %0d want %0d",
                                    seen.beam_length, due.beam_length));
        end
      end
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[bnsh_pkg::REG_IDX_BIT])
          bnsh_pkg::REG_MAX_LENGTH:  max_len_reg = pwdata[bnsh_pkg::LEN_W-1:0];
          bnsh_pkg::REG_BEAM_MARGIN: margin_reg  = pwdata[bnsh_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      // input beat
      if (push && !full) begin
        if (op == bnsh_pkg::OP_SHOT) begin
          shooter       = body_index;
          shooter_at[0] = longint'(pos_x);
          shooter_at[1] = longint'(pos_y);
          shooter_at[2] = longint'(pos_z);
          aim[0]        = longint'(dir_x);
          aim[1]        = longint'(dir_y);
          aim[2]        = longint'(dir_z);
          range_kept    = beam_range;
          nearest_along = max_len_reg;
          nearest_id    = '0;
          struck        = 1'b0;
        end else begin
          weigh_body(body_index, pos_x, pos_y, pos_z, radius, alive);
        end
        if (last) begin
          due.hit         = struck;
          due.hit_index   = struck ? nearest_id : '0;
          due.beam_length = struck ? nearest_along : range_kept;
          due_results.push_back(due);
        end
      end
    end
    due_count = due_results.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS   = 190;
  localparam int ONE           = 1 << 16;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic                       op;
    logic [bnsh_pkg::IDX_W-1:0] idx;
    logic signed [31:0]         px;
    logic signed [31:0]         py;
    logic signed [31:0]         pz;
    logic signed [15:0]         dx;
    logic signed [15:0]         dy;
    logic signed [15:0]         dz;
    logic [bnsh_pkg::LEN_W-1:0] rad;
    logic                       live;
    logic [bnsh_pkg::LEN_W-1:0] reach;
    logic                       fin;
  } beam_item_t;

  logic                        clk;
  logic                        rst;
  logic                        push;
  logic                        full;
  logic                        op;
  logic [bnsh_pkg::IDX_W-1:0]  body_index;
  logic signed [31:0]          pos_x;
  logic signed [31:0]          pos_y;
  logic signed [31:0]          pos_z;
  logic signed [15:0]          dir_x;
  logic signed [15:0]          dir_y;
  logic signed [15:0]          dir_z;
  logic [bnsh_pkg::LEN_W-1:0]  radius;
  logic                        alive;
  logic [bnsh_pkg::LEN_W-1:0]  beam_range;
  logic                        last;
  logic                        empty;
  logic                        pop;
  logic                        hit;
  logic [bnsh_pkg::IDX_W-1:0]  hit_index;
  logic [bnsh_pkg::LEN_W-1:0]  beam_length;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bnsh_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  int mismatches;
  int outstanding;

  bit     sender_naps;
  bit     reader_naps;
  int     items_sent;
  longint cur_at [3];
  longint cur_dir [3];
  logic [bnsh_pkg::IDX_W-1:0] cur_idx;
  longint last_t;

  beam_nearest_sphere_hit DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .op(op), .body_index(body_index),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .radius(radius), .alive(alive), .beam_range(beam_range), .last(last),
    .empty(empty), .pop(pop), .hit(hit), .hit_index(hit_index), .beam_length(beam_length),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  beam_hit_checker beam_check (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .op(op), .body_index(body_index),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .radius(radius), .alive(alive), .beam_range(beam_range), .last(last),
    .empty(empty), .pop(pop), .hit(hit), .hit_index(hit_index), .beam_length(beam_length),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side, with random stall bursts
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (reader_naps && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // one input beat, optionally after an idle burst
  task automatic send_item(input beam_item_t it);
    if (sender_naps && $urandom_range(0, 9) == 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk);
    end
    @(negedge clk);
    push       <= 1'b1;
    op         <= it.op;
    body_index <= it.idx;
    pos_x      <= it.px;
    pos_y      <= it.py;
    pos_z      <= it.pz;
    dir_x      <= it.dx;
    dir_y      <= it.dy;
    dir_z      <= it.dz;
    radius     <= it.rad;
    alive      <= it.live;
    beam_range <= it.reach;
    last       <= it.fin;
    forever begin
      @(posedge clk);
      if (!full)
        break;
    end
    items_sent++;
  endtask

  task automatic write_reg(input logic sel, input logic [bnsh_pkg::LEN_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bnsh_pkg::ADDR_W'(sel) << bnsh_pkg::REG_IDX_BIT;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready)
        break;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop sending and wait for every expected result
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
  endtask

  // drained plus time for bodies still in the pipeline
  task automatic quiesce();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // all fields random
  function automatic beam_item_t noise_item();
    beam_item_t it;
    it.op    = 1'($urandom);
    it.idx   = bnsh_pkg::IDX_W'($urandom);
    it.px    = 32'($urandom);
    it.py    = 32'($urandom);
    it.pz    = 32'($urandom);
    it.dx    = 16'(int'($urandom_range(0, 32768)) - 16384);
    it.dy    = 16'(int'($urandom_range(0, 32768)) - 16384);
    it.dz    = 16'(int'($urandom_range(0, 32768)) - 16384);
    it.rad   = bnsh_pkg::LEN_W'($urandom);
    it.live  = 1'($urandom);
    it.reach = bnsh_pkg::LEN_W'($urandom);
    it.fin   = 1'($urandom);
    return it;
  endfunction

  function automatic beam_item_t shot_item(input logic [bnsh_pkg::IDX_W-1:0] idx,
                                           input logic signed [31:0] px,
                                           input logic signed [31:0] py,
                                           input logic signed [31:0] pz,
                                           input logic signed [15:0] dx,
                                           input logic signed [15:0] dy,
                                           input logic signed [15:0] dz,
                                           input logic [bnsh_pkg::LEN_W-1:0] reach,
                                           input logic fin);
    beam_item_t it;
    it       = noise_item();
    it.op    = bnsh_pkg::OP_SHOT;
    it.idx   = idx;
    it.px    = px;
    it.py    = py;
    it.pz    = pz;
    it.dx    = dx;
    it.dy    = dy;
    it.dz    = dz;
    it.reach = reach;
    it.fin   = fin;
    return it;
  endfunction

  function automatic beam_item_t body_item(input logic [bnsh_pkg::IDX_W-1:0] idx,
                                           input logic signed [31:0] px,
                                           input logic signed [31:0] py,
                                           input logic signed [31:0] pz,
                                           input logic [bnsh_pkg::LEN_W-1:0] rad,
                                           input logic live,
                                           input logic fin);
    beam_item_t it;
    it      = noise_item();
    it.op   = bnsh_pkg::OP_BODY;
    it.idx  = idx;
    it.px   = px;
    it.py   = py;
    it.pz   = pz;
    it.rad  = rad;
    it.live = live;
    it.fin  = fin;
    return it;
  endfunction

  // small offset off the beam axis, up to 4.0 either way
  function automatic longint wobble();
    return longint'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  // shot with a near-unit direction in most cases, remembered for the bodies that follow
  function automatic beam_item_t random_shot();
    beam_item_t it;
    real vx, vy, vz, norm;
    int axis;
    it    = noise_item();
    it.op = bnsh_pkg::OP_SHOT;
    if ($urandom_range(0, 7) != 0) begin
      it.px = 32'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
      it.py = 32'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
      it.pz = 32'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
    end
    case ($urandom_range(0, 7))
      0: begin
        // axis aligned, either sign
        axis  = $urandom_range(0, 2);
        it.dx = (axis == 0) ? 16'sd16384 : 16'sd0;
        it.dy = (axis == 1) ? 16'sd16384 : 16'sd0;
        it.dz = (axis == 2) ? 16'sd16384 : 16'sd0;
        if ($urandom_range(0, 1) == 1) begin
          it.dx = -it.dx;
          it.dy = -it.dy;
          it.dz = -it.dz;
        end
      end
      1: ; // non-unit direction from the noise fields
      default: begin
        vx   = real'(int'($urandom_range(0, 2000)) - 1000);
        vy   = real'(int'($urandom_range(0, 2000)) - 1000);
        vz   = real'(int'($urandom_range(0, 2000)) - 1000);
        norm = $sqrt(vx * vx + vy * vy + vz * vz);
        if (norm < 1.0) begin
          vx   = 1.0;
          norm = 1.0;
        end
        it.dx = 16'($rtoi(vx / norm * 16384.0));
        it.dy = 16'($rtoi(vy / norm * 16384.0));
        it.dz = 16'($rtoi(vz / norm * 16384.0));
      end
    endcase
    cur_idx    = it.idx;
    cur_at[0]  = longint'(it.px);
    cur_at[1]  = longint'(it.py);
    cur_at[2]  = longint'(it.pz);
    cur_dir[0] = longint'(it.dx);
    cur_dir[1] = longint'(it.dy);
    cur_dir[2] = longint'(it.dz);
    return it;
  endfunction

  // body mostly placed near the current beam, sometimes dead, behind, the shooter or plain noise
  function automatic beam_item_t random_body();
    beam_item_t it;
    longint t;
    int kind;
    it      = noise_item();
    it.op   = bnsh_pkg::OP_BODY;
    it.live = 1'b1;
    kind    = $urandom_range(0, 99);
    if (kind >= 92)
      return it;
    it.rad = bnsh_pkg::LEN_W'($urandom_range(0, 1 << 18));
    t      = longint'($urandom_range(1, 1 << 24));
    if (kind >= 30 && kind < 36)
      t = last_t;
    else if (kind < 10)
      t = -t;
    last_t = t;
    it.px  = 32'(cur_at[0] + ((cur_dir[0] * t) >>> 14) + wobble());
    it.py  = 32'(cur_at[1] + ((cur_dir[1] * t) >>> 14) + wobble());
    it.pz  = 32'(cur_at[2] + ((cur_dir[2] * t) >>> 14) + wobble());
    if (kind >= 10 && kind < 18)
      it.live = 1'b0;
    if (kind >= 18 && kind < 25)
      it.idx = cur_idx;
    return it;
  endfunction

  // one shot and its bodies, with some broken or noisy sequences
  task automatic random_salvo();
    beam_item_t it;
    int bodies;
    int shape;
    shape = $urandom_range(0, 99);
    if (shape < 5) begin
      repeat ($urandom_range(1, 3)) send_item(noise_item());
    end else begin
      bodies = $urandom_range(0, 10);
      it     = random_shot();
      it.fin = (bodies == 0);
      send_item(it);
      for (int k = 1; k <= bodies; k++) begin
        it     = random_body();
        // a few sequences never close
        it.fin = (k == bodies) && (shape >= 10);
        send_item(it);
      end
      // search carries on past a closing beat
      if (shape >= 90) begin
        it     = random_body();
        it.fin = 1'b1;
        send_item(it);
      end
    end
  endtask

  initial begin
    int  target;
    bit  paused;
    rst         = 1'b1;
    push        = 1'b0;
    op          = bnsh_pkg::OP_SHOT;
    body_index  = '0;
    pos_x       = '0;
    pos_y       = '0;
    pos_z       = '0;
    dir_x       = '0;
    dir_y       = '0;
    dir_z       = '0;
    radius      = '0;
    alive       = 1'b0;
    beam_range  = '0;
    last        = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    sender_naps = 1'b1;
    reader_naps = 1'b1;
    items_sent  = 0;
    last_t      = 1;
    paused      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // body before any shot sees a zero direction
    send_item(body_item(7, 3 * ONE, 0, 0, ONE, 1'b1, 1'b1));
    // shot closing at once
    send_item(shot_item(0, 0, 0, 0, 0, 0, 16384, bnsh_pkg::LEN_MAX, 1'b1));
    // shooter, dead, behind, near, farther, tie, outside, just inside
    send_item(shot_item(1023, 100 * ONE, -50 * ONE, 0, 16384, 0, 0, 1000 * ONE, 1'b0));
    send_item(body_item(1023, 110 * ONE, -50 * ONE, 0, ONE, 1'b1, 1'b0));
    send_item(body_item(3, 105 * ONE, -50 * ONE, 0, ONE, 1'b0, 1'b0));
    send_item(body_item(4, 95 * ONE, -50 * ONE, 0, ONE, 1'b1, 1'b0));
    send_item(body_item(9, 120 * ONE, -50 * ONE + ONE / 2, 0, 0, 1'b1, 1'b0));
    send_item(body_item(10, 130 * ONE, -50 * ONE, 0, ONE, 1'b1, 1'b0));
    send_item(body_item(11, 120 * ONE, -50 * ONE, 0, ONE, 1'b1, 1'b0));
    send_item(body_item(12, 115 * ONE, -47 * ONE, 0, ONE, 1'b1, 1'b0));
    send_item(body_item(13, 115 * ONE, -48 * ONE - 1, 0, ONE, 1'b1, 1'b1));
    // body after the closing beat without a new shot
    send_item(body_item(14, 112 * ONE, -50 * ONE, 0, 0, 1'b1, 1'b1));
    // non-unit direction, along distance too large for 31 bits
    send_item(shot_item(0, POS_MIN, POS_MIN, POS_MIN, 16384, 16384, 16384, 0, 1'b0));
    send_item(body_item(1, POS_MAX, POS_MAX, POS_MAX, bnsh_pkg::LEN_MAX, 1'b1, 1'b1));
    // negative axis, along at and past the 31-bit limit, widest radius
    send_item(shot_item(512, 0, 0, 0, -16384, 0, 0, 1, 1'b0));
    send_item(body_item(0, POS_MIN, 0, 0, ONE, 1'b1, 1'b0));
    send_item(body_item(1, -POS_MAX, 0, 0, ONE, 1'b1, 1'b0));
    send_item(body_item(2, -ONE, POS_MAX, 0, bnsh_pkg::LEN_MAX, 1'b1, 1'b1));
    // diagonal beam down y and z
    send_item(shot_item(5, 0, 0, 0, 0, -11585, -11585, 77 * ONE, 1'b0));
    send_item(body_item(6, 0, -10 * ONE, -10 * ONE, ONE, 1'b1, 1'b1));

    // random phases, each under its own register setting
    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0) begin
        quiesce();
        case (phase)
          1: begin
            write_reg(bnsh_pkg::REG_MAX_LENGTH,
                      bnsh_pkg::LEN_W'($urandom_range(1 << 22, 32'h7FFF_FFFF)));
            write_reg(bnsh_pkg::REG_BEAM_MARGIN, '0);
          end
          2: begin
            write_reg(bnsh_pkg::REG_MAX_LENGTH, '0);
            write_reg(bnsh_pkg::REG_BEAM_MARGIN, bnsh_pkg::MARGIN_RESET);
          end
          3: begin
            write_reg(bnsh_pkg::REG_MAX_LENGTH, bnsh_pkg::LEN_MAX);
            write_reg(bnsh_pkg::REG_BEAM_MARGIN, bnsh_pkg::LEN_MAX);
          end
          4: begin
            write_reg(bnsh_pkg::REG_MAX_LENGTH, bnsh_pkg::LEN_W'(1 << 23));
            write_reg(bnsh_pkg::REG_BEAM_MARGIN, bnsh_pkg::LEN_W'(1 << 17));
          end
          6: begin
            write_reg(bnsh_pkg::REG_MAX_LENGTH, bnsh_pkg::LEN_MAX);
            write_reg(bnsh_pkg::REG_BEAM_MARGIN, bnsh_pkg::MARGIN_RESET);
          end
          default: begin
            write_reg(bnsh_pkg::REG_MAX_LENGTH,
                      bnsh_pkg::LEN_W'($urandom_range(1 << 20, 32'h7FFF_FFFF)));
            write_reg(bnsh_pkg::REG_BEAM_MARGIN,
                      bnsh_pkg::LEN_W'($urandom_range(0, 1 << 18)));
          end
        endcase
      end
      // one stretch with no idling, and none in the closing phase
      sender_naps = (phase != 1) && (phase != 7);
      reader_naps = (phase != 1) && (phase != 7);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (phase == 3 && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        random_salvo();
      end
    end

    quiesce();
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ beam_nearest_sphere_hit.f @@
+incdir+sv
sv/bnsh_pkg.sv
sv/bnsh_queue.sv
sv/bnsh_front.sv
sv/bnsh_back.sv
sv/beam_nearest_sphere_hit.sv
tb/sv/beam_hit_checker.sv
tb/sv/tb_top.sv
